// ===== design/lsf_pkg.sv =====
// Shared types and constants of the line substring filter.
// Depends on nothing; every other file of the block but lsf_ifs imports it.
package lsf_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int PAT_BYTES       = 16;
  localparam int OUT_W           = 16;
  localparam int PLEN_W          = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int Q_DEPTH         = 4;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam logic REC_LINE    = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_idx_t;

  // Work for the back end: an optional line record and an optional summary.
  typedef struct packed {
    logic             rec_valid;
    logic [OUT_W-1:0] line_offset;
    logic [OUT_W-1:0] line_length;
    logic [OUT_W-1:0] line_number;
    logic             sum_valid;
    logic [OUT_W-1:0] match_total;
    logic             nothing_matched;
  } lsf_entry_t;

endpackage

// ===== design/lsf_ifs.sv =====
// Valid/ready channel interfaces for the text input and the result output.
// Depends on nothing; field widths are fixed.
interface lsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       end_of_data;

  modport source (output valid, text_byte, byte_present, end_of_data, input ready);
  modport sink   (input valid, text_byte, byte_present, end_of_data, output ready);
endinterface

interface lsf_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [15:0] line_offset;
  logic [15:0] line_length;
  logic [15:0] line_number;
  logic [15:0] match_total;
  logic        nothing_matched;
  logic        final_result;

  modport source (output valid, record_kind, line_offset, line_length, line_number,
                  match_total, nothing_matched, final_result, input ready);
  modport sink   (input valid, record_kind, line_offset, line_length, line_number,
                  match_total, nothing_matched, final_result, output ready);
endinterface

// ===== design/lsf_front.sv =====
// Front end: configuration registers, byte window, line tracking and match test.
// Depends on lsf_pkg and lsf_in_if; pushes one work entry per item that needs output.
module lsf_front #(
  parameter int PATTERN_MAX = lsf_pkg::PATTERN_MAX_DEF,
  parameter int COUNT_WIDTH = lsf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  lsf_in_if.sink                             in_ch,
  input  logic                               cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               q_full,
  output logic                               push,
  output lsf_pkg::lsf_entry_t                push_entry
);
  import lsf_pkg::*;

  localparam int CW  = COUNT_WIDTH;
  localparam int PLW = $clog2(PATTERN_MAX + 1);

  logic [CFG_DATA_W-1:0] pat_low_r, pat_low_nxt;
  logic [CFG_DATA_W-1:0] pat_high_r, pat_high_nxt;
  logic [PLEN_W-1:0]     pat_len_r, pat_len_nxt;
  logic [PLW-1:0]        plen_r, plen_nxt;
  logic [7:0]            exp_r [PATTERN_MAX];
  logic [7:0]            exp_nxt [PATTERN_MAX];
  logic                  care_r [PATTERN_MAX];
  logic                  care_nxt [PATTERN_MAX];

  logic [7:0]    win_r [PATTERN_MAX];
  logic [7:0]    win_nxt [PATTERN_MAX];
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] loff_r, loff_nxt;
  logic [CW-1:0] soff_r, soff_nxt;
  logic [CW-1:0] lidx_r, lidx_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic          hit_r, hit_nxt;

  logic          accept;
  logic [7:0]    shifted [PATTERN_MAX];
  logic          window_eq;
  logic [CW-1:0] len_inc;
  logic          hit_now;
  lsf_entry_t    entry;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // The pattern is held aligned to the window, newest byte at position 0.
  always_comb begin
    logic [2*CFG_DATA_W-1:0] pat_all;
    int                      plen_i;
    int                      k;
    pat_low_nxt  = pat_low_r;
    pat_high_nxt = pat_high_r;
    pat_len_nxt  = pat_len_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_LOW:  pat_low_nxt  = cfg_wdata;
        CFG_PAT_HIGH: pat_high_nxt = cfg_wdata;
        CFG_PAT_LEN:  pat_len_nxt  = cfg_wdata[PLEN_W-1:0];
        default: ;
      endcase
    end
    pat_all  = {pat_high_nxt, pat_low_nxt};
    plen_i   = (int'(pat_len_nxt) > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_nxt);
    plen_nxt = PLW'(plen_i);
    for (int j = 0; j < PATTERN_MAX; j++) begin
      k           = plen_i - 1 - j;
      care_nxt[j] = (j < plen_i);
      exp_nxt[j]  = 8'd0;
      if (j < plen_i && k < PAT_BYTES) begin
        exp_nxt[j] = pat_all[{4'(k), 3'b000} +: 8];
      end
    end
  end

  always_comb begin
    shifted[0] = in_ch.text_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      shifted[j] = win_r[j-1];
    end
    window_eq = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (care_r[j] && shifted[j] != exp_r[j]) begin
        window_eq = 1'b0;
      end
    end
    len_inc = sat_inc(len_r);
    hit_now = (plen_r != '0) && (len_inc >= CW'(plen_r)) && window_eq;
  end

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;

  always_comb begin
    logic [CW-1:0] next_off;
    next_off  = sat_inc(soff_r);
    win_nxt   = win_r;
    len_nxt   = len_r;
    loff_nxt  = loff_r;
    soff_nxt  = soff_r;
    lidx_nxt  = lidx_r;
    total_nxt = total_r;
    hit_nxt   = hit_r;
    entry     = '0;
    if (in_ch.byte_present) begin
      if (in_ch.text_byte == NEWLINE_BYTE) begin
        if (hit_r || plen_r == '0) begin
          entry.rec_valid   = 1'b1;
          entry.line_offset = OUT_W'(loff_r);
          entry.line_length = OUT_W'(len_r);
          entry.line_number = OUT_W'(lidx_r);
          total_nxt         = sat_inc(total_r);
        end
        lidx_nxt = sat_inc(lidx_r);
        len_nxt  = '0;
        loff_nxt = next_off;
        hit_nxt  = 1'b0;
      end else begin
        win_nxt = shifted;
        len_nxt = len_inc;
        if (hit_now) begin
          hit_nxt = 1'b1;
        end
      end
      soff_nxt = next_off;
    end
    if (in_ch.end_of_data) begin
      if (len_nxt != '0 && (hit_nxt || plen_r == '0)) begin
        entry.rec_valid   = 1'b1;
        entry.line_offset = OUT_W'(loff_nxt);
        entry.line_length = OUT_W'(len_nxt);
        entry.line_number = OUT_W'(lidx_nxt);
        total_nxt         = sat_inc(total_nxt);
      end
      entry.sum_valid       = 1'b1;
      entry.match_total     = OUT_W'(total_nxt);
      entry.nothing_matched = (total_nxt == '0);
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win_nxt[j] = 8'd0;
      end
      len_nxt   = '0;
      loff_nxt  = '0;
      soff_nxt  = '0;
      lidx_nxt  = '0;
      total_nxt = '0;
      hit_nxt   = 1'b0;
    end
  end

  assign push       = accept && (entry.rec_valid || entry.sum_valid);
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      plen_r     <= '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        exp_r[j]  <= 8'd0;
        care_r[j] <= 1'b0;
        win_r[j]  <= 8'd0;
      end
      len_r   <= '0;
      loff_r  <= '0;
      soff_r  <= '0;
      lidx_r  <= '0;
      total_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      pat_low_r  <= pat_low_nxt;
      pat_high_r <= pat_high_nxt;
      pat_len_r  <= pat_len_nxt;
      plen_r     <= plen_nxt;
      exp_r      <= exp_nxt;
      care_r     <= care_nxt;
      if (accept) begin
        win_r   <= win_nxt;
        len_r   <= len_nxt;
        loff_r  <= loff_nxt;
        soff_r  <= soff_nxt;
        lidx_r  <= lidx_nxt;
        total_r <= total_nxt;
        hit_r   <= hit_nxt;
      end
    end
  end

  a_stream_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_data) |=> (soff_r == '0 && total_r == '0 && lidx_r == '0))
    else $error("stream state not cleared after end of data");

endmodule

// ===== design/lsf_queue.sv =====
// Short work queue between the front and back ends of the line substring filter.
// Depends on lsf_pkg for the entry type and depth.
module lsf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lsf_pkg::lsf_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output lsf_pkg::lsf_entry_t head
);
  import lsf_pkg::*;

  localparam int AW = $clog2(Q_DEPTH);
  localparam int NW = $clog2(Q_DEPTH + 1);

  lsf_entry_t    slots_r [Q_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [NW-1:0] count_r, count_nxt;

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_entry;
    end
  end

  assign full  = (count_r == NW'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("work queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("work queue read while empty");

endmodule

// ===== design/lsf_back.sv =====
// Back end: turns queued work entries into result transfers, one per cycle while the output is ready.
// Depends on lsf_pkg and lsf_out_if; the result payload sits in an output register.
module lsf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  lsf_pkg::lsf_entry_t head,
  output logic                pop,
  lsf_out_if.source           out_ch
);
  import lsf_pkg::*;

  logic        valid_r, valid_nxt;
  logic        rec_done_r, rec_done_nxt;
  logic        kind_r, kind_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] num_r, num_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic        none_r, none_nxt;
  logic        final_r, final_nxt;
  logic        load;

  assign load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt    = valid_r;
    rec_done_nxt = rec_done_r;
    kind_nxt     = kind_r;
    off_nxt      = off_r;
    len_nxt      = len_r;
    num_nxt      = num_r;
    tot_nxt      = tot_r;
    none_nxt     = none_r;
    final_nxt    = final_r;
    pop          = 1'b0;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        if (head.rec_valid && !rec_done_r) begin
          kind_nxt  = REC_LINE;
          off_nxt   = head.line_offset;
          len_nxt   = head.line_length;
          num_nxt   = head.line_number;
          tot_nxt   = '0;
          none_nxt  = 1'b0;
          final_nxt = !head.sum_valid;
          if (head.sum_valid) begin
            rec_done_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          kind_nxt     = REC_SUMMARY;
          off_nxt      = '0;
          len_nxt      = '0;
          num_nxt      = '0;
          tot_nxt      = head.match_total;
          none_nxt     = head.nothing_matched;
          final_nxt    = 1'b1;
          rec_done_nxt = 1'b0;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      rec_done_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      rec_done_r <= rec_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    off_r   <= off_nxt;
    len_r   <= len_nxt;
    num_r   <= num_nxt;
    tot_r   <= tot_nxt;
    none_r  <= none_nxt;
    final_r <= final_nxt;
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.record_kind     = kind_r;
  assign out_ch.line_offset     = off_r;
  assign out_ch.line_length     = len_r;
  assign out_ch.line_number     = num_r;
  assign out_ch.match_total     = tot_r;
  assign out_ch.nothing_matched = none_r;
  assign out_ch.final_result    = final_r;

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r == REC_SUMMARY) |-> final_r)
    else $error("summary not marked as the last result of its item");

endmodule

// ===== design/line_substring_filter.sv =====
// Top level of the line substring filter: front end, work queue and back end.
// Depends on lsf_pkg, lsf_ifs, lsf_front, lsf_queue and lsf_back.
//
// The filter takes one text byte per clock cycle while the queue has room and reports each
// line that contains the configured fixed pattern (up to sixteen bytes), or every line when
// the pattern is empty, as a record of offset, length and line number, followed by a
// summary record when an item carries end of data. The pattern test over the byte window is
// done in the accepting cycle, so input is stalled only when the four-entry work queue is
// full; a result goes through the queue to the output register and leaves at one result per
// cycle while the output is ready. An item with end of data can cause two results, so a
// stream of such items is limited by the single result port. Configuration is taken on any
// cycle the write enable is high and should be changed only while no results are outstanding.
module line_substring_filter #(
  parameter int PATTERN_MAX = lsf_pkg::PATTERN_MAX_DEF,
  parameter int COUNT_WIDTH = lsf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lsf_in_if.sink                         in_ch,
  lsf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lsf_pkg::*;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  lsf_entry_t q_in;
  lsf_entry_t q_head;

  lsf_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  lsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  lsf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (q_empty),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== bench/line_substring_filter_test.sv =====
// Self-checking bench for line_substring_filter: streams text bytes, predicts every line record
// and end-of-data summary, and compares each result transfer field by field.
// Depends on lsf_pkg, the channel interfaces in lsf_ifs and the line_substring_filter RTL.
module line_substring_filter_test;
  import lsf_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 900;
  localparam int PHASE_ITEMS   = 130;
  localparam int MAX_REPORTS   = 200;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       present;
    logic       eod;
  } text_item_t;

  typedef struct packed {
    logic             kind;
    logic [OUT_W-1:0] offset;
    logic [OUT_W-1:0] length;
    logic [OUT_W-1:0] number;
    logic [OUT_W-1:0] total;
    logic             none;
    logic             last;
  } line_rec_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_PAT_LOW;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lsf_in_if  text_ch ();
  lsf_out_if rec_ch ();

  line_substring_filter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (text_ch),
    .out_ch   (rec_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Pattern registers as the bench believes them to be.
  logic [63:0]       pat_low_q = '0;
  logic [63:0]       pat_high_q = '0;
  logic [PLEN_W-1:0] pat_len_q = '0;

  // Running state of the filter.
  logic [7:0]       window_bytes [PAT_BYTES];
  logic [OUT_W-1:0] line_len = '0;
  logic [OUT_W-1:0] line_start = '0;
  logic [OUT_W-1:0] stream_pos = '0;
  logic [OUT_W-1:0] line_idx = '0;
  logic             line_hit = 1'b0;
  logic [OUT_W-1:0] hit_count = '0;

  text_item_t text_items [$];
  line_rec_t  awaited_records [$];
  logic [7:0] line_bytes [$];
  text_item_t next_item;

  int  fed = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  cycles = 0;
  int  in_hold = 0;
  int  out_hold = 0;
  bit  steady = 1'b0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  bit  settled = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic int pattern_span();
    return (pat_len_q > PAT_BYTES) ? PAT_BYTES : int'(pat_len_q);
  endfunction

  function automatic logic [7:0] pattern_byte(input int i);
    if (i < 8) begin
      return pat_low_q[8*i +: 8];
    end
    return pat_high_q[8*(i-8) +: 8];
  endfunction

  function automatic bit window_hit();
    int n, i;
    n = pattern_span();
    if (n == 0 || line_len < n) begin
      return 1'b0;
    end
    for (i = 0; i < n; i++) begin
      if (window_bytes[n-1-i] != pattern_byte(i)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int draw_gap();
    if (steady || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  task automatic clear_stream();
    int i;
    for (i = 0; i < PAT_BYTES; i++) begin
      window_bytes[i] = '0;
    end
    line_len = '0;
    line_start = '0;
    stream_pos = '0;
    line_idx = '0;
    line_hit = 1'b0;
    hit_count = '0;
  endtask

  task automatic close_line(input logic [OUT_W-1:0] next_start, inout int made);
    line_rec_t r;
    if (line_hit || pattern_span() == 0) begin
      r = '0;
      r.kind = REC_LINE;
      r.offset = line_start;
      r.length = line_len;
      r.number = line_idx;
      awaited_records.push_back(r);
      hit_count = bump(hit_count);
      made++;
    end
    line_idx = bump(line_idx);
    line_len = '0;
    line_start = next_start;
    line_hit = 1'b0;
  endtask

  task automatic predict_item(input logic [7:0] b, input logic present, input logic eod);
    int made, i;
    logic [OUT_W-1:0] next_pos;
    line_rec_t r;
    made = 0;
    if (present) begin
      next_pos = bump(stream_pos);
      if (b == NEWLINE_BYTE) begin
        close_line(next_pos, made);
      end else begin
        for (i = PAT_BYTES - 1; i > 0; i--) begin
          window_bytes[i] = window_bytes[i-1];
        end
        window_bytes[0] = b;
        line_len = bump(line_len);
        if (window_hit()) begin
          line_hit = 1'b1;
        end
      end
      stream_pos = next_pos;
    end
    if (eod) begin
      if (line_len != 0) begin
        close_line(stream_pos, made);
      end
      r = '0;
      r.kind = REC_SUMMARY;
      r.total = hit_count;
      r.none = (hit_count == 0);
      awaited_records.push_back(r);
      made++;
      clear_stream();
    end
    if (made > 0) begin
      r = awaited_records.pop_back();
      r.last = 1'b1;
      awaited_records.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch on result transfer %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_record();
    line_rec_t want;
    if (awaited_records.size() == 0) begin
      report_mismatch("record with none awaited", rec_ch.record_kind, 0);
      return;
    end
    want = awaited_records.pop_front();
    if (rec_ch.record_kind !== want.kind) begin
      report_mismatch("record_kind", rec_ch.record_kind, want.kind);
    end
    if (rec_ch.line_offset !== want.offset) begin
      report_mismatch("line_offset", rec_ch.line_offset, want.offset);
    end
    if (rec_ch.line_length !== want.length) begin
      report_mismatch("line_length", rec_ch.line_length, want.length);
    end
    if (rec_ch.line_number !== want.number) begin
      report_mismatch("line_number", rec_ch.line_number, want.number);
    end
    if (rec_ch.match_total !== want.total) begin
      report_mismatch("match_total", rec_ch.match_total, want.total);
    end
    if (rec_ch.nothing_matched !== want.none) begin
      report_mismatch("nothing_matched", rec_ch.nothing_matched, want.none);
    end
    if (rec_ch.final_result !== want.last) begin
      report_mismatch("final_result", rec_ch.final_result, want.last);
    end
  endtask

  // Prediction and checking both happen at the rising edge on which a transfer completes.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("line_substring_filter verification failed");
      $finish;
    end
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
      settled <= 1'b0;
    end else begin
      in_took <= text_ch.valid && text_ch.ready;
      out_took <= rec_ch.valid && rec_ch.ready;
      if (text_ch.valid && text_ch.ready) begin
        predict_item(text_ch.text_byte, text_ch.byte_present, text_ch.end_of_data);
      end
      if (rec_ch.valid && rec_ch.ready) begin
        results_seen++;
        check_record();
      end
      settled <= text_items.size() == 0 && (!text_ch.valid || text_ch.ready) &&
                 awaited_records.size() == 0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      text_ch.valid <= 1'b0;
      text_ch.text_byte <= '0;
      text_ch.byte_present <= 1'b0;
      text_ch.end_of_data <= 1'b0;
      in_hold = 0;
    end else if (!text_ch.valid || in_took) begin
      if (in_hold > 0) begin
        text_ch.valid <= 1'b0;
        in_hold--;
      end else if (text_items.size() > 0) begin
        next_item = text_items.pop_front();
        text_ch.valid <= 1'b1;
        text_ch.text_byte <= next_item.text_byte;
        text_ch.byte_present <= next_item.present;
        text_ch.end_of_data <= next_item.eod;
        in_hold = draw_gap();
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      rec_ch.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_took) begin
        out_hold = draw_gap();
      end
      if (out_hold > 0) begin
        rec_ch.ready <= 1'b0;
        out_hold--;
      end else begin
        rec_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input logic [7:0] b, input logic present, input logic eod);
    text_item_t it;
    it.text_byte = b;
    it.present = present;
    it.eod = eod;
    text_items.push_back(it);
    if (present || eod) begin
      fed++;
    end
  endtask

  task automatic set_pattern(input logic [63:0] low, input logic [63:0] high,
                             input logic [63:0] span);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PAT_LOW;
    cfg_wdata <= low;
    @(negedge clk);
    cfg_index <= CFG_PAT_HIGH;
    cfg_wdata <= high;
    @(negedge clk);
    cfg_index <= CFG_PAT_LEN;
    cfg_wdata <= span;
    @(negedge clk);
    cfg_we <= 1'b0;
    pat_low_q = low;
    pat_high_q = high;
    pat_len_q = span[PLEN_W-1:0];
  endtask

  // Returns once every transfer has completed and the pipeline has had time to empty.
  task automatic wait_idle();
    do @(negedge clk);
    while (!settled);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Line body drawn partly from the pattern's own bytes so that near misses are common.
  task automatic build_line(input int body, input bit plant);
    int n, i, at;
    logic [7:0] b;
    n = pattern_span();
    line_bytes.delete();
    for (i = 0; i < body; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          b = (n > 0) ? pattern_byte($urandom_range(0, n - 1)) : 8'($urandom_range(97, 100));
        end
        4, 5, 6: begin
          b = 8'($urandom_range(97, 100));
        end
        default: begin
          b = 8'($urandom_range(0, 255));
        end
      endcase
      if (b == NEWLINE_BYTE) begin
        b = 8'h0B;
      end
      line_bytes.push_back(b);
    end
    if (plant && n > 0) begin
      at = $urandom_range(0, body);
      for (i = 0; i < n; i++) begin
        line_bytes.insert(at + i, pattern_byte(i));
      end
    end
  endtask

  task automatic queue_stream();
    int lines, i, j, ending;
    bit last_line;
    lines = $urandom_range(1, 6);
    for (i = 0; i < lines; i++) begin
      last_line = (i == lines - 1);
      ending = $urandom_range(0, 3);
      build_line(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 24),
                 $urandom_range(0, 9) < 6);
      for (j = 0; j < line_bytes.size(); j++) begin
        if ($urandom_range(0, 15) == 0) begin
          queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        queue_item(line_bytes[j], 1'b1,
                   last_line && ending == 1 && j == line_bytes.size() - 1);
      end
      if (!last_line) begin
        queue_item(NEWLINE_BYTE, 1'b1, 1'b0);
      end else begin
        case (ending)
          0: begin
            queue_item(NEWLINE_BYTE, 1'b1, 1'b0);
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          end
          1: begin
            if (line_bytes.size() == 0) begin
              queue_item(NEWLINE_BYTE, 1'b1, 1'b1);
            end
          end
          2: begin
            queue_item(NEWLINE_BYTE, 1'b1, 1'b1);
          end
          default: begin
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          end
        endcase
      end
    end
  endtask

  initial begin
    int p, phase_end;
    logic [63:0] low, high, span;
    text_ch.valid = 1'b0;
    text_ch.text_byte = '0;
    text_ch.byte_present = 1'b0;
    text_ch.end_of_data = 1'b0;
    rec_ch.ready = 1'b0;
    clear_stream();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: an empty pattern takes every line, empty ones too.
    queue_item(8'hFF, 1'b0, 1'b1);
    queue_item(NEWLINE_BYTE, 1'b1, 1'b0);
    queue_item(8'h00, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0);
    queue_item(NEWLINE_BYTE, 1'b0, 1'b0);
    queue_item(NEWLINE_BYTE, 1'b1, 1'b0);
    queue_item("q", 1'b1, 1'b1);
    wait_idle();

    // Two-byte pattern: a hit, a pattern split over two lines, a trailing newline at end
    // of data and a stream with no hit at all.
    set_pattern(64'h6261, '1, 64'd2);
    queue_item("x", 1'b1, 1'b0);
    queue_item("a", 1'b1, 1'b0);
    queue_item("b", 1'b1, 1'b0);
    queue_item("y", 1'b1, 1'b0);
    queue_item(NEWLINE_BYTE, 1'b1, 1'b0);
    queue_item("a", 1'b1, 1'b0);
    queue_item(NEWLINE_BYTE, 1'b1, 1'b0);
    queue_item("b", 1'b1, 1'b0);
    queue_item(NEWLINE_BYTE, 1'b1, 1'b0);
    queue_item("a", 1'b1, 1'b0);
    queue_item("b", 1'b1, 1'b0);
    queue_item(NEWLINE_BYTE, 1'b1, 1'b1);
    queue_item("z", 1'b1, 1'b0);
    queue_item("z", 1'b1, 1'b1);
    wait_idle();

    p = 0;
    while (fed < RANDOM_ITEMS) begin
      low = {$urandom, $urandom};
      high = {$urandom, $urandom};
      span = {$urandom, $urandom};
      case (p)
        0: begin
          span[PLEN_W-1:0] = 5'd16;
        end
        1: begin
          span[PLEN_W-1:0] = 5'd31;
        end
        2: begin
          span[PLEN_W-1:0] = 5'd1;
        end
        3: begin
          low = '0;
          high = '0;
          span = '0;
        end
        4: begin
          low = '1;
          high = '1;
          span = 64'd16;
        end
        default: begin
          span[PLEN_W-1:0] = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                                           5'($urandom_range(2, 5));
        end
      endcase
      steady = ($urandom_range(0, 3) == 0);
      set_pattern(low, high, span);
      phase_end = fed + PHASE_ITEMS;
      while (fed < phase_end) begin
        queue_stream();
      end
      wait_idle();
      p++;
    end

    if (mismatches == 0) begin
      $display("line_substring_filter verification clean");
    end else begin
      $display("line_substring_filter verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lsf_pkg.sv
design/lsf_ifs.sv
design/lsf_front.sv
design/lsf_queue.sv
design/lsf_back.sv
design/line_substring_filter.sv
bench/line_substring_filter_test.sv
